// File: design/bdeg_pkg.sv
`default_nettype none

package bdeg_pkg;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_HOLD    = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_FIRST_HOLD  = 2'd1,
    REG_REPEAT_HOLD = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned TicksWidth = 24;

  localparam logic [CfgWidth-1:0] DebounceRst    = 16'd20;
  localparam logic [CfgWidth-1:0] FirstHoldRst   = 16'd400;
  localparam logic [CfgWidth-1:0] RepeatHoldRst  = 16'd80;

endpackage

`default_nettype wire

// File: design/button_debounce_event_generator.sv
// Debouncer and event generator for one active-low push button.
// Input channel (in_valid_i/in_ready_o): one word per millisecond tick carrying
// the raw pin level (0 = pressed). Output channel (out_valid_o/out_ready_i):
// exactly one word per input word with event code (none/press/release/hold),
// click and hold_fire pulses, debounced state and pressed duration.
// Config: cfg_we_i writes register cfg_idx_i at the clock edge: 0 debounce,
// 1 first hold, 2 repeat hold (16 bits each); index 3 is ignored. Write only
// while no word is in flight.
// The result word is registered and presented in the cycle after the input
// word is taken. Throughput: one word per cycle unless the receiver stalls;
// all per-tick work is one layer of counter increment, subtract and compare
// between the state registers and the output register.
// Stall: the output register holds while out_ready_i is low; a new input word
// is taken in the same cycle the held word leaves, so in_ready_o drops only
// while a word waits and the receiver is stalled.
// Reset: released state, counters zero, registers at 20/400/80, no word held.
`default_nettype none

module button_debounce_event_generator #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bdeg_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [bdeg_pkg::CfgWidth-1:0]        cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 pin_level_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [1:0]                                event_code_o,
  output logic                                      click_o,
  output logic                                      hold_fire_o,
  output logic                                      pressed_o,
  output logic [bdeg_pkg::TicksWidth-1:0]           pressed_ticks_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > bdeg_pkg::CfgWidth) ?
                                 COUNT_WIDTH : bdeg_pkg::CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  // configuration
  logic [bdeg_pkg::CfgWidth-1:0] debounce_q, first_hold_q, repeat_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= bdeg_pkg::DebounceRst;
      first_hold_q  <= bdeg_pkg::FirstHoldRst;
      repeat_hold_q <= bdeg_pkg::RepeatHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdeg_pkg::REG_DEBOUNCE:    debounce_q    <= cfg_wdata_i;
        bdeg_pkg::REG_FIRST_HOLD:  first_hold_q  <= cfg_wdata_i;
        bdeg_pkg::REG_REPEAT_HOLD: repeat_hold_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // tick state
  logic                     raw_prev_q, raw_prev_d;
  logic                     stable_q, stable_d;
  logic [COUNT_WIDTH-1:0]   steady_q, steady_d;
  logic [COUNT_WIDTH-1:0]   press_q, press_d;
  logic [COUNT_WIDTH-1:0]   reported_q, reported_d;
  logic                     phase_q, phase_d;
  bdeg_pkg::event_e         last_ev_q, last_ev_d;

  logic                     in_fire;
  logic [COUNT_WIDTH-1:0]   steady_inc, press_inc, cur, diff;
  logic [bdeg_pkg::CfgWidth-1:0] thr;
  bdeg_pkg::event_e         ev;
  logic                     click, hold;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    steady_inc = (steady_q == CntMax) ? steady_q : steady_q + COUNT_WIDTH'(1);
    press_inc  = (press_q == CntMax) ? press_q : press_q + COUNT_WIDTH'(1);
    thr        = phase_q ? repeat_hold_q : first_hold_q;

    raw_prev_d = raw_prev_q;
    stable_d   = stable_q;
    steady_d   = steady_inc;
    press_d    = press_inc;
    if (pin_level_i != raw_prev_q) begin
      raw_prev_d = pin_level_i;
      steady_d   = '0;
    end else if (pin_level_i != stable_q) begin
      if (CmpW'(steady_inc) > CmpW'(debounce_q)) begin
        stable_d = pin_level_i;
        press_d  = COUNT_WIDTH'(1);
      end
    end

    cur  = stable_d ? '0 : press_d;
    diff = cur - reported_q;

    ev         = bdeg_pkg::EV_NONE;
    reported_d = reported_q;
    phase_d    = phase_q;
    if (reported_q != cur) begin
      if (cur == '0) begin
        ev         = bdeg_pkg::EV_RELEASE;
        reported_d = cur;
        phase_d    = 1'b0;
      end else if (reported_q == '0) begin
        ev         = bdeg_pkg::EV_PRESS;
        reported_d = cur;
        phase_d    = 1'b0;
      end else if (cur > reported_q && CmpW'(diff) > CmpW'(thr)) begin
        ev         = bdeg_pkg::EV_HOLD;
        reported_d = cur;
        phase_d    = 1'b1;
      end
    end

    click     = (ev == bdeg_pkg::EV_RELEASE) && (last_ev_q == bdeg_pkg::EV_PRESS);
    hold      = (ev == bdeg_pkg::EV_HOLD);
    last_ev_d = (ev == bdeg_pkg::EV_NONE) ? last_ev_q : ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q <= 1'b1;
      stable_q   <= 1'b1;
      steady_q   <= '0;
      press_q    <= '0;
      reported_q <= '0;
      phase_q    <= 1'b0;
      last_ev_q  <= bdeg_pkg::EV_NONE;
    end else if (in_fire) begin
      raw_prev_q <= raw_prev_d;
      stable_q   <= stable_d;
      steady_q   <= steady_d;
      press_q    <= press_d;
      reported_q <= reported_d;
      phase_q    <= phase_d;
      last_ev_q  <= last_ev_d;
    end
  end

  // output register
  logic                            out_valid_q, out_valid_d;
  bdeg_pkg::event_e                ev_q;
  logic                            click_q, hold_q, pressed_q;
  logic [bdeg_pkg::TicksWidth-1:0] ticks_q, ticks_d;

  generate
    if (COUNT_WIDTH >= bdeg_pkg::TicksWidth) begin : g_ticks_trunc
      assign ticks_d = cur[bdeg_pkg::TicksWidth-1:0];
    end else begin : g_ticks_ext
      assign ticks_d = bdeg_pkg::TicksWidth'(cur);
    end
  endgenerate

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q      <= ev;
      click_q   <= click;
      hold_q    <= hold;
      pressed_q <= !stable_d;
      ticks_q   <= ticks_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = ev_q;
  assign click_o         = click_q;
  assign hold_fire_o     = hold_q;
  assign pressed_o       = pressed_q;
  assign pressed_ticks_o = ticks_q;

  // released state always has reported the zero duration
  a_released_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stable_q |-> (reported_q == '0))
    else $error("reported duration nonzero while released");

  a_click_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && click_o) |-> (event_code_o == bdeg_pkg::EV_RELEASE))
    else $error("click without release event");

  a_hold_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hold_fire_o == (event_code_o == bdeg_pkg::EV_HOLD)))
    else $error("hold_fire does not match hold event");

  a_ticks_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pressed_o) |-> (pressed_ticks_o == '0))
    else $error("nonzero duration while released");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input blocked without a stalled word");

endmodule

`default_nettype wire
